// File: hw/rtl/mpp_pkg.sv
// Shared types and constants for the MQTT packet parser.
// Used by the front end, the result queue and the output stage.
package mpp_pkg;

    localparam int RX_W      = 8;
    localparam int LEN_W     = 28;
    localparam int TDATA_W   = 80;
    localparam int TUSER_W   = 3;

    // Result kinds
    localparam logic [2:0] K_HEADER = 3'd0;
    localparam logic [2:0] K_TOPIC  = 3'd1;
    localparam logic [2:0] K_ID     = 3'd2;
    localparam logic [2:0] K_BODY   = 3'd3;
    localparam logic [2:0] K_BAD    = 3'd4;

    // Packet types of interest
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;
    localparam logic [3:0] TYPE_ID_LAST = 4'd11;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       data_byte;
        logic [3:0]       packet_type;
        logic [1:0]       qos_level;
        logic [LEN_W-1:0] remaining_length;
        logic [15:0]      pkt_id;
        logic [15:0]      topic_length;
        logic             last_of_packet;
    } result_t;

endpackage

// File: hw/rtl/mqtt_packet_parser_top.sv
// MQTT control-packet parser, top level.
// Instantiates mpp_front, mpp_queue and mpp_back; depends on mpp_pkg.
//
// Usage:
//   s_* channel takes the received byte stream, one byte per item, packets
//   placed back to back. m_* channel gives the results: a header per packet,
//   then topic bytes, message id and payload bytes; m_tlast marks the result
//   that ends a packet, and malformed packets give one result of kind 4.
//   Throughput is one byte per cycle while s_tready is high: every byte
//   updates the parser state as it is accepted. A result reaches m_tvalid
//   through the queue write, then the output register load.
//   When the receiver stalls, results collect in a QUEUE_DEPTH-entry queue;
//   s_tready drops only once the queue is full, so bytes that give no result
//   are still taken until then.
//   Reset empties the queue, clears the output valid flag and sets the parser
//   to expect the first byte of a packet.
module mqtt_packet_parser_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [7:0] data_byte, [11:8] packet_type, [13:12] qos_level,
    // [41:14] remaining_length, [57:42] pkt_id, [73:58] topic_length
    output logic [mpp_pkg::TDATA_W-1:0] m_tdata,
    output logic [mpp_pkg::TUSER_W-1:0] m_tuser,   // [2:0] kind
    output logic                        m_tlast    // last_of_packet
);
    import mpp_pkg::*;

    logic    accept;
    logic    push;
    result_t res;
    logic    q_ready;
    logic    q_pop;
    logic    q_empty;
    result_t q_data;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;

    mpp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .push    (push),
        .res     (res)
    );

    mpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (res),
        .ready   (q_ready),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_data (q_data)
    );

    mpp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: hw/rtl/mpp_front.sv
// Front end of the MQTT packet parser: takes one byte per item, tracks the
// packet phase and builds at most one result per byte. Depends on mpp_pkg.
module mpp_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [mpp_pkg::RX_W-1:0] rx_byte,
    output logic                     push,
    output mpp_pkg::result_t         res
);
    import mpp_pkg::*;

    localparam logic [2:0] PH_FIRST = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_TLEN  = 3'd2;
    localparam logic [2:0] PH_TOPIC = 3'd3;
    localparam logic [2:0] PH_ID    = 3'd4;
    localparam logic [2:0] PH_BODY  = 3'd5;
    localparam logic [2:0] PH_SKIP  = 3'd6;

    logic [2:0]       phase_reg, phase_next;
    logic [3:0]       type_reg, type_next;
    logic [1:0]       qos_reg, qos_next;
    logic [LEN_W-1:0] accum_reg, accum_next;
    logic [1:0]       idx_reg, idx_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [15:0]      tlen_reg, tlen_next;
    logic [15:0]      count_reg, count_next;
    logic [7:0]       idh_reg, idh_next;

    logic [LEN_W-1:0] left_dec;
    logic             pkt_end;
    logic [LEN_W-1:0] group;
    logic [LEN_W-1:0] accum_new;
    logic [15:0]      tlen_full;
    logic [15:0]      count_inc;
    logic [2:0]       after_topic;
    logic             emit;
    logic [2:0]       kind;
    logic [15:0]      msg_id;
    logic             last;

    always_comb
    begin
        left_dec    = (left_reg != '0) ? left_reg - LEN_W'(1) : left_reg;
        pkt_end     = (left_dec == '0);
        tlen_full   = {tlen_reg[15:8], rx_byte};
        count_inc   = count_reg + 16'd1;
        after_topic = (qos_reg != 2'd0) ? PH_ID : PH_BODY;
        case (idx_reg)
            2'd0:    group = {21'd0, rx_byte[6:0]};
            2'd1:    group = {14'd0, rx_byte[6:0], 7'd0};
            2'd2:    group = {7'd0, rx_byte[6:0], 14'd0};
            default: group = {rx_byte[6:0], 21'd0};
        endcase
        accum_new   = accum_reg | group;

        phase_next = phase_reg;
        type_next  = type_reg;
        qos_next   = qos_reg;
        accum_next = accum_reg;
        idx_next   = idx_reg;
        left_next  = left_reg;
        tlen_next  = tlen_reg;
        count_next = count_reg;
        idh_next   = idh_reg;
        emit       = 1'b0;
        kind       = K_HEADER;
        msg_id     = 16'd0;
        last       = 1'b0;

        case (phase_reg)
            PH_FIRST:
            begin
                type_next  = rx_byte[7:4];
                qos_next   = rx_byte[2:1];
                accum_next = '0;
                idx_next   = 2'd0;
                left_next  = '0;
                tlen_next  = 16'd0;
                count_next = 16'd0;
                idh_next   = 8'd0;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                accum_next = accum_new;
                if (rx_byte[7])
                begin
                    if (idx_reg == 2'd3)
                    begin
                        emit       = 1'b1;
                        kind       = K_BAD;
                        last       = 1'b1;
                        phase_next = PH_FIRST;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                else
                begin
                    left_next  = accum_new;
                    count_next = 16'd0;
                    emit       = 1'b1;
                    kind       = K_HEADER;
                    if (accum_new == '0)
                    begin
                        last       = 1'b1;
                        phase_next = PH_FIRST;
                    end
                    else if (type_reg == TYPE_PUBLISH)
                        phase_next = PH_TLEN;
                    else if (type_reg > TYPE_PUBLISH && type_reg <= TYPE_ID_LAST)
                        phase_next = PH_ID;
                    else
                        phase_next = PH_BODY;
                end
            end
            PH_TLEN:
            begin
                left_next = left_dec;
                if (count_reg == 16'd0)
                begin
                    tlen_next  = {rx_byte, 8'd0};
                    count_next = 16'd1;
                    if (pkt_end)
                    begin
                        emit       = 1'b1;
                        kind       = K_BAD;
                        last       = 1'b1;
                        phase_next = PH_FIRST;
                    end
                end
                else
                begin
                    tlen_next  = tlen_full;
                    count_next = 16'd0;
                    if (({12'd0, tlen_full} > left_dec) || (pkt_end && tlen_full == 16'd0))
                    begin
                        emit       = 1'b1;
                        kind       = K_BAD;
                        last       = 1'b1;
                        phase_next = pkt_end ? PH_FIRST : PH_SKIP;
                    end
                    else
                        phase_next = (tlen_full != 16'd0) ? PH_TOPIC : after_topic;
                end
            end
            PH_TOPIC:
            begin
                left_next  = left_dec;
                emit       = 1'b1;
                kind       = K_TOPIC;
                last       = pkt_end;
                count_next = count_inc;
                if (pkt_end)
                    phase_next = PH_FIRST;
                else if (count_inc == tlen_reg)
                begin
                    count_next = 16'd0;
                    phase_next = after_topic;
                end
            end
            PH_ID:
            begin
                left_next = left_dec;
                if (count_reg == 16'd0)
                begin
                    idh_next   = rx_byte;
                    count_next = 16'd1;
                    if (pkt_end)
                    begin
                        emit       = 1'b1;
                        kind       = K_BAD;
                        last       = 1'b1;
                        phase_next = PH_FIRST;
                    end
                end
                else
                begin
                    count_next = 16'd0;
                    emit       = 1'b1;
                    kind       = K_ID;
                    msg_id     = {idh_reg, rx_byte};
                    last       = pkt_end;
                    phase_next = pkt_end ? PH_FIRST : PH_BODY;
                end
            end
            PH_BODY:
            begin
                left_next = left_dec;
                emit      = 1'b1;
                kind      = K_BODY;
                last      = pkt_end;
                if (pkt_end)
                    phase_next = PH_FIRST;
            end
            PH_SKIP:
            begin
                left_next = left_dec;
                if (pkt_end)
                    phase_next = PH_FIRST;
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase

        // Fields reflect the state as updated by this byte
        res.kind             = kind;
        res.data_byte        = (kind == K_TOPIC || kind == K_BODY) ? rx_byte : 8'd0;
        res.packet_type      = type_next;
        res.qos_level        = qos_next;
        res.remaining_length = accum_next;
        res.pkt_id           = msg_id;
        res.topic_length     = tlen_next;
        res.last_of_packet   = last;
        push                 = accept && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            type_reg  <= 4'd0;
            qos_reg   <= 2'd0;
            accum_reg <= '0;
            idx_reg   <= 2'd0;
            left_reg  <= '0;
            tlen_reg  <= 16'd0;
            count_reg <= 16'd0;
            idh_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            qos_reg   <= qos_next;
            accum_reg <= accum_next;
            idx_reg   <= idx_next;
            left_reg  <= left_next;
            tlen_reg  <= tlen_next;
            count_reg <= count_next;
            idh_reg   <= idh_next;
        end
    end

endmodule

// File: hw/rtl/mpp_queue.sv
// Short result queue between the parser front end and the output stage.
// Register-based circular buffer. Depends on mpp_pkg.
module mpp_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mpp_pkg::result_t wr_data,
    output logic             ready,
    input  logic             pop,
    output logic             empty,
    output mpp_pkg::result_t rd_data
);
    import mpp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    result_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign ready   = (cnt_reg != FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: hw/rtl/mpp_back.sv
// Output stage of the MQTT packet parser: pulls results from the queue into
// a registered stream port and packs the fields. Depends on mpp_pkg.
module mpp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  mpp_pkg::result_t            q_data,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mpp_pkg::TDATA_W-1:0] m_tdata,
    output logic [mpp_pkg::TUSER_W-1:0] m_tuser,
    output logic                        m_tlast
);
    import mpp_pkg::*;

    logic    valid_reg, valid_next;
    result_t out_reg;
    logic    load;

    assign load       = !valid_reg || m_tready;
    assign q_pop      = load && !q_empty;
    assign valid_next = load ? !q_empty : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_reg <= q_data;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last_of_packet;
    assign m_tdata  = {6'd0,
                       out_reg.topic_length,
                       out_reg.pkt_id,
                       out_reg.remaining_length,
                       out_reg.qos_level,
                       out_reg.packet_type,
                       out_reg.data_byte};

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for mqtt_packet_parser_top: streams MQTT packets, predicts every result.
// Depends on mpp_pkg and mqtt_packet_parser_top.
module tb_top;

    import mpp_pkg::*;

    typedef enum logic [2:0] {
        ST_FIRST, ST_LEN, ST_TLEN, ST_TOPIC, ST_ID, ST_BODY, ST_SKIP
    } parse_st_t;

    localparam int ITEM_COUNT  = 1250;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 20;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = 8'h00;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [TUSER_W-1:0]  m_tuser;
    logic                m_tlast;

    logic [7:0]          rx_stream[$];
    result_t             due_results[$];
    result_t             want, got;
    int                  errors = 0;
    int                  idle_cycles = 0;

    // predictor state
    parse_st_t           parse_st = ST_FIRST;
    logic [3:0]          p_type = '0;
    logic [1:0]          p_qos = '0;
    logic [LEN_W-1:0]    len_acc = '0;
    logic [1:0]          len_idx = '0;
    logic [LEN_W-1:0]    remain = '0;
    logic [15:0]         tlen = '0;
    logic [15:0]         fidx = '0;
    logic [7:0]          id_hi = '0;

    int                  burst_left = 0;
    int                  gap_left = 0;
    int                  rx_cyc = 0;
    int                  rx_mode = 0;
    int                  hold_left = 0;

    mqtt_packet_parser_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic result_t make_result(input logic [2:0] kind, input logic [7:0] data,
                                            input logic [15:0] id, input logic last);
        result_t r;
        r.kind             = kind;
        r.data_byte        = data;
        r.packet_type      = p_type;
        r.qos_level        = p_qos;
        r.remaining_length = len_acc;
        r.pkt_id           = id;
        r.topic_length     = tlen;
        r.last_of_packet   = last;
        return r;
    endfunction

    function automatic parse_st_t after_topic();
        return (p_qos != 2'd0) ? ST_ID : ST_BODY;
    endfunction

    // Advance the parser by one byte and queue the result it causes, if any.
    function automatic void parse_rx_byte(input logic [7:0] b);
        logic fin;
        if (parse_st == ST_FIRST)
        begin
            p_type   = b[7:4];
            p_qos    = b[2:1];
            len_acc  = '0;
            len_idx  = '0;
            remain   = '0;
            tlen     = '0;
            fidx     = '0;
            id_hi    = '0;
            parse_st = ST_LEN;
        end
        else if (parse_st == ST_LEN)
        begin
            len_acc = len_acc | (LEN_W'(b[6:0]) << (7 * len_idx));
            if (b[7])
            begin
                if (len_idx == 2'd3)
                begin
                    due_results.push_back(make_result(K_BAD, 8'h00, 16'h0000, 1'b1));
                    parse_st = ST_FIRST;
                end
                else
                    len_idx = len_idx + 2'd1;
            end
            else
            begin
                remain = len_acc;
                fidx   = '0;
                if (remain == '0)
                begin
                    due_results.push_back(make_result(K_HEADER, 8'h00, 16'h0000, 1'b1));
                    parse_st = ST_FIRST;
                end
                else
                begin
                    due_results.push_back(make_result(K_HEADER, 8'h00, 16'h0000, 1'b0));
                    if (p_type == TYPE_PUBLISH)
                        parse_st = ST_TLEN;
                    else if (p_type > TYPE_PUBLISH && p_type <= TYPE_ID_LAST)
                        parse_st = ST_ID;
                    else
                        parse_st = ST_BODY;
                end
            end
        end
        else
        begin
            if (remain != '0)
                remain = remain - LEN_W'(1);
            fin = (remain == '0);
            case (parse_st)
                ST_TLEN:
                begin
                    if (fidx == '0)
                    begin
                        tlen = {b, 8'h00};
                        fidx = 16'd1;
                        if (fin)
                        begin
                            due_results.push_back(make_result(K_BAD, 8'h00, 16'h0000, 1'b1));
                            parse_st = ST_FIRST;
                        end
                    end
                    else
                    begin
                        tlen = tlen | 16'(b);
                        fidx = '0;
                        if (LEN_W'(tlen) > remain || (fin && tlen == '0))
                        begin
                            due_results.push_back(make_result(K_BAD, 8'h00, 16'h0000, 1'b1));
                            parse_st = fin ? ST_FIRST : ST_SKIP;
                        end
                        else
                            parse_st = (tlen != '0) ? ST_TOPIC : after_topic();
                    end
                end
                ST_TOPIC:
                begin
                    due_results.push_back(make_result(K_TOPIC, b, 16'h0000, fin));
                    fidx = fidx + 16'd1;
                    if (fin)
                        parse_st = ST_FIRST;
                    else if (fidx == tlen)
                    begin
                        fidx     = '0;
                        parse_st = after_topic();
                    end
                end
                ST_ID:
                begin
                    if (fidx == '0)
                    begin
                        id_hi = b;
                        fidx  = 16'd1;
                        if (fin)
                        begin
                            due_results.push_back(make_result(K_BAD, 8'h00, 16'h0000, 1'b1));
                            parse_st = ST_FIRST;
                        end
                    end
                    else
                    begin
                        fidx = '0;
                        due_results.push_back(make_result(K_ID, 8'h00, {id_hi, b}, fin));
                        parse_st = fin ? ST_FIRST : ST_BODY;
                    end
                end
                ST_BODY:
                begin
                    due_results.push_back(make_result(K_BODY, b, 16'h0000, fin));
                    if (fin)
                        parse_st = ST_FIRST;
                end
                default:
                begin
                    // drop the rest of a packet whose topic did not fit
                    if (fin)
                        parse_st = ST_FIRST;
                end
            endcase
        end
    endfunction

    // Append a remaining-length field, optionally padded with redundant zero groups.
    task automatic push_length(input int len, input bit pad);
        logic [7:0] grp[$];
        int         rest;
        int         n;
        rest = len;
        do
        begin
            grp.push_back({1'b0, rest[6:0]});
            rest = rest >> 7;
        end
        while (rest > 0);
        if (pad && grp.size() < 4)
            repeat ($urandom_range(1, 4 - grp.size())) grp.push_back(8'h00);
        for (n = 0; n < grp.size() - 1; n++)
            grp[n][7] = 1'b1;
        for (n = 0; n < grp.size(); n++)
            rx_stream.push_back(grp[n]);
    endtask

    // Append one packet: mostly well-formed with random content, some broken on purpose.
    task automatic add_packet();
        int         pick;
        int         plen;
        int         tl;
        int         k;
        logic [3:0] ptype;
        logic [1:0] qos;
        logic [7:0] body[$];
        pick = $urandom_range(0, 99);
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
        qos  = 2'($urandom_range(0, 3));
        if (pick >= 75 && pick < 82)
        begin
            // length field that never terminates
            rx_stream.push_back(8'($urandom));
            repeat (4) rx_stream.push_back(8'($urandom) | 8'h80);
            return;
        end
        if (pick < 40)
        begin
            ptype = TYPE_PUBLISH;
            tl = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            body.push_back(8'(tl >> 8));
            body.push_back(8'(tl));
            repeat (tl) body.push_back(8'($urandom));
            if (qos != 2'd0)
                repeat (2) body.push_back(8'($urandom));
        end
        else if (pick < 60)
        begin
            ptype = 4'($urandom_range(4, 11));
            repeat (2) body.push_back(8'($urandom));
        end
        else if (pick < 75)
        begin
            k = $urandom_range(0, 6);
            ptype = (k < 3) ? 4'(k) : 4'(k + 9);
        end
        else if (pick < 90)
        begin
            // topic length larger than what is left of the packet
            ptype = TYPE_PUBLISH;
            plen  = $urandom_range(0, 8);
            tl = ($urandom_range(0, 3) == 0) ? 16'hFFFF : plen + $urandom_range(1, 40);
            body.push_back(8'(tl >> 8));
            body.push_back(8'(tl));
            repeat (plen) body.push_back(8'($urandom));
            plen = 0;
        end
        else
        begin
            // short packet, which may end inside a topic length or id field
            ptype = ($urandom_range(0, 1) == 1) ? TYPE_PUBLISH : 4'($urandom_range(4, 11));
            repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
            plen = 0;
        end
        repeat (plen) body.push_back(8'($urandom));
        rx_stream.push_back({ptype, 1'($urandom), qos, 1'($urandom)});
        push_length(body.size(), $urandom_range(0, 7) == 0);
        for (k = 0; k < body.size(); k++)
            rx_stream.push_back(body[k]);
    endtask

    task automatic check_field(input string name, input logic [LEN_W-1:0] exp_val,
                               input logic [LEN_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 8'h00;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0 || rx_stream.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_stream.pop_front();
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // receiver: stall pattern changes periodically, plus long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_cyc    = 0;
            rx_mode   = 0;
            hold_left = 0;
        end
        else
        begin
            rx_cyc++;
            if (rx_cyc % 97 == 0)
                rx_mode = $urandom_range(0, 3);
            if (rx_cyc == 400 || rx_cyc == 2500)
                hold_left = LONG_HOLD;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // check results, then predict from the byte taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind             = m_tuser[2:0];
                got.data_byte        = m_tdata[7:0];
                got.packet_type      = m_tdata[11:8];
                got.qos_level        = m_tdata[13:12];
                got.remaining_length = m_tdata[41:14];
                got.pkt_id           = m_tdata[57:42];
                got.topic_length     = m_tdata[73:58];
                got.last_of_packet   = m_tlast;
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual kind %0d tdata 0x%0h",
                             $time, got.kind, m_tdata);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", LEN_W'(want.kind), LEN_W'(got.kind));
                    check_field("data_byte", LEN_W'(want.data_byte), LEN_W'(got.data_byte));
                    check_field("packet_type", LEN_W'(want.packet_type),
                                LEN_W'(got.packet_type));
                    check_field("qos_level", LEN_W'(want.qos_level), LEN_W'(got.qos_level));
                    check_field("remaining_length", want.remaining_length,
                                got.remaining_length);
                    check_field("pkt_id", LEN_W'(want.pkt_id), LEN_W'(got.pkt_id));
                    check_field("topic_length", LEN_W'(want.topic_length),
                                LEN_W'(got.topic_length));
                    check_field("last_of_packet", LEN_W'(want.last_of_packet),
                                LEN_W'(got.last_of_packet));
                end
            end
            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata);
            // the longest quiet stretch is a hold-off plus a slow receiver, far below this
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, due_results.size());
                $display("FAIL mqtt_packet_parser_top");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] directed[] = '{
            8'hC0, 8'h00,                               // zero remaining length
            8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF,          // length field runs past four bytes
            8'h32, 8'h03, 8'h00, 8'h01, 8'h5A,          // topic fills the packet
            8'h30, 8'h04, 8'h00, 8'h05, 8'h00, 8'hFF,   // topic longer than packet
            8'h40, 8'h01, 8'hAB,                        // packet ends in id high byte
            8'h62, 8'h04, 8'h12, 8'h34, 8'h00, 8'hFF    // id then payload
        };
        foreach (directed[i])
            rx_stream.push_back(directed[i]);
        while (rx_stream.size() < ITEM_COUNT)
            add_packet();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_stream.size() != 0 || s_tvalid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("PASS mqtt_packet_parser_top");
        else
            $display("FAIL mqtt_packet_parser_top");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mpp_pkg.sv
hw/rtl/mpp_front.sv
hw/rtl/mpp_queue.sv
hw/rtl/mpp_back.sv
hw/rtl/mqtt_packet_parser_top.sv
dv/tb_top.sv
